// File: rtl/priority_quantum_scheduler_assert.svh
// Assertion macros for the priority quantum scheduler
`ifndef PRIORITY_QUANTUM_SCHEDULER_ASSERT_SVH
`define PRIORITY_QUANTUM_SCHEDULER_ASSERT_SVH

`ifndef SYNTH
`define PQS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PQS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PQS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PQS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/pqs_pkg.sv
// Shared types and constants for the priority quantum scheduler
package pqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam logic [15:0] QUANTUM_RESET = 16'd10;
    localparam logic [7:0] PRI_MAX = 8'hFF;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [7:0]  prio;
        logic [19:0] total;
        logic [19:0] done;
    } t_slot;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } t_chain_op;

    typedef struct packed {
        t_chain_op op;
        logic      reinsert;
    } t_chain_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_REINS
    } t_state;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_DISPATCH = 2'd2,
        STAT_EMPTY    = 2'd3
    } t_status;

endpackage

// File: rtl/pqs_cell.sv
// One queue slot of the sorted shifting chain
module pqs_cell import pqs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chain_cmd i_cmd,
    input  t_slot      i_new,
    input  t_slot      i_left,
    input  logic       i_left_valid,
    input  logic       i_left_flag,
    input  t_slot      i_right,
    input  logic       i_right_valid,
    output t_slot      o_slot,
    output logic       o_valid,
    output logic       o_flag
);

    t_slot r_slot;
    t_slot n_slot;
    logic  r_valid;
    logic  n_valid;
    logic  w_after;

    always_comb begin
        if (i_cmd.reinsert) begin
            w_after = r_slot.prio > i_new.prio;
        end else begin
            w_after = (r_slot.prio > i_new.prio) ||
                      ((r_slot.prio == i_new.prio) &&
                       (r_slot.arrival > i_new.arrival));
        end
        o_flag = !r_valid || w_after;
    end

    always_comb begin
        n_slot  = r_slot;
        n_valid = r_valid;
        unique case (i_cmd.op)
            OP_INSERT: begin
                if (o_flag) begin
                    if (!i_left_flag) begin
                        n_slot  = i_new;
                        n_valid = 1'b1;
                    end else begin
                        n_slot  = i_left;
                        n_valid = i_left_valid;
                    end
                end
            end
            OP_POP: begin
                n_slot  = i_right;
                n_valid = i_right_valid;
            end
            default: begin
                n_slot  = r_slot;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_slot  = r_slot;
    assign o_valid = r_valid;

endmodule

// File: rtl/priority_quantum_scheduler.sv
// Priority quantum scheduler top level: control, quantum register and slot chain
//
//  channel | direction | handshake                   | word
//  in      | input     | i_in_valid / o_in_ready     | kind, task id, arrival, priority, cycles
//  out     | output    | o_out_valid / i_out_ready   | status, run id/priority/cycles, finished, count
//  cfg     | input     | i_cfg_valid / o_cfg_ready   | quantum
//
//  Insert, full drop, empty dispatch and finishing dispatch complete in ST_IDLE alone.
//  A dispatch that puts its task back pops it, then reinserts it from ST_REINS.
//  Both run as one shift of the slot chain per cycle.
//  Reset empties the queue at once and loads quantum with 10; no clearing pass.
//  A waiting result blocks new words; the cfg port is always ready.
module priority_quantum_scheduler import pqs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_kind,
    input  logic [15:0]   i_task_id,
    input  logic [31:0]   i_arrival_time,
    input  logic [7:0]    i_priority_req,
    input  logic [19:0]   i_total_cycles,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [1:0]    o_status,
    output logic [15:0]   o_run_id,
    output logic [7:0]    o_run_priority,
    output logic [15:0]   o_run_cycles,
    output logic          o_finished,
    output logic [CW-1:0] o_queue_count,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [15:0]   i_cfg_data
);

`include "priority_quantum_scheduler_assert.svh"

    t_state        r_state;
    t_state        n_state;
    logic [15:0]   r_quantum;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_slot         r_re;
    t_slot         n_re;
    logic          r_out_valid;
    t_status       r_status;
    t_status       n_status;
    logic [15:0]   r_run_id;
    logic [15:0]   n_run_id;
    logic [7:0]    r_run_pri;
    logic [7:0]    n_run_pri;
    logic [15:0]   r_run_cyc;
    logic [15:0]   n_run_cyc;
    logic          r_fin;
    logic          n_fin;

    t_chain_cmd w_cmd;
    t_slot      w_new;
    t_slot      w_slot  [QUEUE_DEPTH];
    logic       w_valid [QUEUE_DEPTH];
    logic       w_flag  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid_vec;

    logic        w_acc;
    logic        w_full;
    logic        w_empty;
    t_slot       w_head;
    logic [19:0] w_rem;
    logic [15:0] w_run;
    logic [19:0] w_ndone;
    logic        w_unfin;
    logic [7:0]  w_np;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_slot w_left;
            logic  w_left_valid;
            logic  w_left_flag;
            t_slot w_right;
            logic  w_right_valid;
            if (g == 0) begin : g_first
                assign w_left       = '0;
                assign w_left_valid = 1'b0;
                assign w_left_flag  = 1'b0;
            end else begin : g_mid
                assign w_left       = w_slot[g-1];
                assign w_left_valid = w_valid[g-1];
                assign w_left_flag  = w_flag[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_right       = '0;
                assign w_right_valid = 1'b0;
            end else begin : g_inner
                assign w_right       = w_slot[g+1];
                assign w_right_valid = w_valid[g+1];
            end
            pqs_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (w_cmd),
                .i_new         (w_new),
                .i_left        (w_left),
                .i_left_valid  (w_left_valid),
                .i_left_flag   (w_left_flag),
                .i_right       (w_right),
                .i_right_valid (w_right_valid),
                .o_slot        (w_slot[g]),
                .o_valid       (w_valid[g]),
                .o_flag        (w_flag[g])
            );
            assign w_valid_vec[g] = w_valid[g];
        end
    endgenerate

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_full      = r_count == CW'(QUEUE_DEPTH);
    assign w_empty     = r_count == '0;
    assign w_head      = w_slot[0];

    always_comb begin
        w_rem   = (w_head.done >= w_head.total) ? 20'd0 : w_head.total - w_head.done;
        w_run   = (w_rem > {4'd0, r_quantum}) ? r_quantum : w_rem[15:0];
        w_ndone = w_head.done + {4'd0, w_run};
        w_unfin = w_ndone < w_head.total;
        w_np    = (w_head.prio == PRI_MAX) ? PRI_MAX : w_head.prio + 8'd1;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_re      = r_re;
        n_status  = r_status;
        n_run_id  = r_run_id;
        n_run_pri = r_run_pri;
        n_run_cyc = r_run_cyc;
        n_fin     = r_fin;
        w_cmd     = '{op: OP_HOLD, reinsert: 1'b0};
        w_new     = '{id: i_task_id, arrival: i_arrival_time, prio: i_priority_req,
                      total: i_total_cycles, done: 20'd0};
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_run_id  = '0;
                    n_run_pri = '0;
                    n_run_cyc = '0;
                    n_fin     = 1'b0;
                    if (!i_kind) begin
                        if (w_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_status = STAT_INSERTED;
                            w_cmd    = '{op: OP_INSERT, reinsert: 1'b0};
                            n_count  = r_count + CW'(1);
                        end
                    end else if (w_empty) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_status  = STAT_DISPATCH;
                        n_run_id  = w_head.id;
                        n_run_pri = w_head.prio;
                        n_run_cyc = w_run;
                        n_fin     = !w_unfin;
                        w_cmd     = '{op: OP_POP, reinsert: 1'b0};
                        n_re      = '{id: w_head.id, arrival: w_head.arrival, prio: w_np,
                                      total: w_head.total, done: w_ndone};
                        if (w_unfin) begin
                            n_state = ST_REINS;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
            end
            ST_REINS: begin
                w_cmd   = '{op: OP_INSERT, reinsert: 1'b1};
                w_new   = r_re;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_re      <= n_re;
        r_status  <= n_status;
        r_run_id  <= n_run_id;
        r_run_pri <= n_run_pri;
        r_run_cyc <= n_run_cyc;
        r_fin     <= n_fin;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_quantum   <= QUANTUM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_quantum <= i_cfg_data;
            end
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_run_id       = r_run_id;
    assign o_run_priority = r_run_pri;
    assign o_run_cycles   = r_run_cyc;
    assign o_finished     = r_fin;
    assign o_queue_count  = r_count;

    `PQS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(QUEUE_DEPTH), "count over depth")
    `PQS_ASSERT(a_count_valid, i_clk, i_rst_n, (r_state == ST_IDLE) |-> ($countones(w_valid_vec) == int'(r_count)), "valid bits disagree with count")
    `PQS_ASSERT(a_sorted, i_clk, i_rst_n, ((r_state == ST_IDLE) && w_valid[1]) |-> (w_slot[0].prio <= w_slot[1].prio), "head out of order")
    `PQS_ASSERT(a_dispatch, i_clk, i_rst_n, (w_acc && i_kind && !w_empty) |=> (o_status == STAT_DISPATCH), "dispatch not reported")

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the priority quantum scheduler with a scoreboard class
module testbench import pqs_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_INSERT   = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;
    localparam int   IDLE_LIMIT    = 2000;
    localparam int   SETTLE_CYCLES = 6;
    localparam int   LONG_STALL    = 150;
    localparam int   PHASE_ITEMS   = 85;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [7:0]  prio;
        logic [19:0] total;
        logic [19:0] done;
    } t_task_entry;

    typedef struct packed {
        t_status     status;
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] cycles;
        logic        fin;
        logic [4:0]  count;
    } t_grant;

    class t_run_ledger;
        t_task_entry ready_list[$];
        t_grant      pending_grants[$];
        logic [15:0] quantum = QUANTUM_RESET;
        int          faults  = 0;

        function void post_word(logic kind, logic [15:0] id, logic [31:0] arr,
                                logic [7:0] pri, logic [19:0] tot);
            t_grant      g;
            t_task_entry e;
            int          pos;
            logic [19:0] left;
            logic [19:0] run;
            g = '0;
            if (kind == KIND_INSERT) begin
                if (ready_list.size() >= QUEUE_DEPTH_DEF) begin
                    g.status = STAT_FULL;
                end else begin
                    pos = 0;
                    while (pos < ready_list.size() &&
                           (ready_list[pos].prio < pri ||
                            (ready_list[pos].prio == pri && ready_list[pos].arrival <= arr)))
                        pos++;
                    e.id      = id;
                    e.arrival = arr;
                    e.prio    = pri;
                    e.total   = tot;
                    e.done    = '0;
                    ready_list.insert(pos, e);
                    g.status = STAT_INSERTED;
                end
            end else if (ready_list.size() == 0) begin
                g.status = STAT_EMPTY;
            end else begin
                e = ready_list.pop_front();
                left = (e.done >= e.total) ? 20'd0 : e.total - e.done;
                run = (left > {4'd0, quantum}) ? {4'd0, quantum} : left;
                g.status = STAT_DISPATCH;
                g.id     = e.id;
                g.prio   = e.prio;
                g.cycles = run[15:0];
                e.done   = e.done + run;
                if (e.done < e.total) begin
                    if (e.prio != PRI_MAX)
                        e.prio = e.prio + 8'd1;
                    pos = 0;
                    while (pos < ready_list.size() && ready_list[pos].prio <= e.prio)
                        pos++;
                    ready_list.insert(pos, e);
                end else begin
                    g.fin = 1'b1;
                end
            end
            g.count = 5'(ready_list.size());
            pending_grants.push_back(g);
        endfunction

        function void match_result(t_grant got);
            t_grant want;
            if (pending_grants.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("[%0t] result with no word outstanding: st=%0d id=%h", $realtime,
                             got.status, got.id);
                return;
            end
            want = pending_grants.pop_front();
            if (want !== got) begin
                faults++;
                if (faults <= 10)
                    $display({"[%0t] mismatch: expected st=%0d id=%h pri=%0d cyc=%0d fin=%0d ",
                              "cnt=%0d, got st=%0d id=%h pri=%0d cyc=%0d fin=%0d cnt=%0d"},
                             $realtime, want.status, want.id, want.prio, want.cycles, want.fin,
                             want.count, got.status, got.id, got.prio, got.cycles, got.fin,
                             got.count);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        in_kind = KIND_INSERT;
    logic [15:0] in_task_id = '0;
    logic [31:0] in_arrival = '0;
    logic [7:0]  in_priority = '0;
    logic [19:0] in_total = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  out_status;
    logic [15:0] out_run_id;
    logic [7:0]  out_run_priority;
    logic [15:0] out_run_cycles;
    logic        out_finished;
    logic [4:0]  out_queue_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    t_run_ledger ledger = new();
    int          stall_request = 0;
    int          words_sent = 0;

    priority_quantum_scheduler u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_kind         (in_kind),
        .i_task_id      (in_task_id),
        .i_arrival_time (in_arrival),
        .i_priority_req (in_priority),
        .i_total_cycles (in_total),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_status       (out_status),
        .o_run_id       (out_run_id),
        .o_run_priority (out_run_priority),
        .o_run_cycles   (out_run_cycles),
        .o_finished     (out_finished),
        .o_queue_count  (out_queue_count),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic int draw_gap(int seq);
        if ((seq / 20) % 4 == 3)
            return 0;
        return int'($urandom_range(0, 6));
    endfunction

    task automatic send_word(logic kind, logic [15:0] id, logic [31:0] arr,
                             logic [7:0] pri, logic [19:0] tot);
        int gap;
        gap = draw_gap(words_sent);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_kind     <= kind;
        in_task_id  <= id;
        in_arrival  <= arr;
        in_priority <= pri;
        in_total    <= tot;
        do @(posedge clk); while (!in_ready);
        ledger.post_word(kind, id, arr, pri, tot);
        words_sent++;
    endtask

    task automatic send_random(int insert_pct);
        logic        kind;
        logic [15:0] id;
        logic [31:0] arr;
        logic [7:0]  pri;
        logic [19:0] tot;
        kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_DISPATCH;
        id = 16'($urandom);
        arr = $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 3) << 16);
        case ($urandom_range(0, 3))
            0: pri = 8'($urandom);
            1: pri = 8'($urandom_range(252, 255));
            default: pri = 8'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 7))
            0: tot = 20'($urandom);
            1: tot = '0;
            default: tot = 20'($urandom_range(1, 40));
        endcase
        send_word(kind, id, arr, pri, tot);
    endtask

    task automatic run_phase(int count);
        int pct;
        for (int i = 0; i < count; i++) begin
            if (i % 15 == 0) begin
                case ($urandom_range(0, 2))
                    0: pct = 25;
                    1: pct = 50;
                    default: pct = 75;
                endcase
            end
            send_random(pct);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (ledger.pending_grants.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_quantum(logic [15:0] q);
        cfg_valid <= 1'b1;
        cfg_data  <= q;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ledger.quantum = q;
    endtask

    initial begin : result_sink
        int     gap;
        int     taken;
        t_grant got;
        taken = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (stall_request > 0) begin
                gap = stall_request;
                stall_request = 0;
            end else begin
                gap = draw_gap(taken);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.status = t_status'(out_status);
            got.id     = out_run_id;
            got.prio   = out_run_priority;
            got.cycles = out_run_cycles;
            got.fin    = out_finished;
            got.count  = out_queue_count;
            ledger.match_result(got);
            taken++;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] quanta [4];
        quanta[0] = 16'hFFFF;
        quanta[1] = 16'd0;
        quanta[2] = 16'd1;
        quanta[3] = 16'($urandom_range(2, 65534));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(KIND_DISPATCH, 16'hA5A5, 32'h5A5A_5A5A, 8'h3C, 20'hC3C3C);
        send_word(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 20'hFFFFF);
        send_word(KIND_INSERT, 16'h0000, 32'h0000_0000, 8'h00, 20'd0);
        send_word(KIND_INSERT, 16'h0001, 32'h0000_0000, 8'h00, 20'd5);
        send_word(KIND_INSERT, 16'h0002, 32'h0001_0000, 8'hFE, 20'd25);
        repeat (5) send_word(KIND_DISPATCH, 16'h0000, 32'h0000_0000, 8'h00, 20'd0);
        // fill to the top, last one overflows
        repeat (15) send_random(100);
        run_phase(PHASE_ITEMS);

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            write_quantum(quanta[ph]);
            if (ph == 0)
                stall_request = LONG_STALL;
            run_phase(PHASE_ITEMS);
        end
        settle();

        if (ledger.faults == 0 && ledger.pending_grants.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
